@@ rtl/core/segment_intersection_test_top_macros.svh @@
// Assertion macros for the segment intersection test block.
`ifndef SEGMENT_INTERSECTION_TEST_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SIT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sit_pkg.sv @@
// Shared types and constants for the segment intersection test block.
package sit_pkg;

   // Four orientation tests: a1 and a2 against segment b, b1 and b2 against segment a.
   localparam int NUM_ORIENT = 4;
   localparam int NUM_SEG    = 2;

   // Sign of one cross product: strictly positive, strictly negative, or neither.
   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

endpackage

@@ rtl/core/sit_req_if.sv @@
// Request channel carrying the two segments.
interface sit_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_start_x;
   logic signed [COORD_WIDTH-1:0] first_start_y;
   logic signed [COORD_WIDTH-1:0] first_end_x;
   logic signed [COORD_WIDTH-1:0] first_end_y;
   logic signed [COORD_WIDTH-1:0] second_start_x;
   logic signed [COORD_WIDTH-1:0] second_start_y;
   logic signed [COORD_WIDTH-1:0] second_end_x;
   logic signed [COORD_WIDTH-1:0] second_end_y;

   modport source (
      output valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      input  ready
   );

   modport sink (
      input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
             second_start_x, second_start_y, second_end_x, second_end_y,
      output ready
   );
endinterface

@@ rtl/core/sit_rsp_if.sv @@
// Response channel carrying the meet flag.
interface sit_rsp_if;
   logic valid;
   logic ready;
   logic segments_meet;

   modport source (output valid, segments_meet, input ready);
   modport sink   (input valid, segments_meet, output ready);
endinterface

@@ rtl/core/segment_intersection_test_top.sv @@
// Top level of the segment intersection test block.
// Decides whether two closed segments, given by signed integer endpoints of COORD_WIDTH
// bits, cross or touch. A four-stage pipeline takes one request per clock unless the response
// stalls: stage one forms the coordinate differences and the bounding-box compares, stage
// two the eight full-width products, stage three the signs of the four cross products, and
// the output register the final decision. The whole pipeline advances together whenever
// the output register is empty or its result is being taken, so a stalled response holds
// every stage and nothing is lost. Interface widths must match COORD_WIDTH.
// No state is kept between requests.
`include "segment_intersection_test_top_macros.svh"

module segment_intersection_test_top
   import sit_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   sit_req_if.sink  req,
   sit_rsp_if.source rsp
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   // Pipeline enable: move everything when the output slot is free or being taken.
   logic advance;
   logic rsp_valid_ff;
   logic meet_ff;
   logic v1_ff, v2_ff, v3_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Widen the endpoints by one bit so differences cannot wrap.
   logic signed [DW-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
   assign a1x = {req.first_start_x[COORD_WIDTH-1],  req.first_start_x};
   assign a1y = {req.first_start_y[COORD_WIDTH-1],  req.first_start_y};
   assign a2x = {req.first_end_x[COORD_WIDTH-1],    req.first_end_x};
   assign a2y = {req.first_end_y[COORD_WIDTH-1],    req.first_end_y};
   assign b1x = {req.second_start_x[COORD_WIDTH-1], req.second_start_x};
   assign b1y = {req.second_start_y[COORD_WIDTH-1], req.second_start_y};
   assign b2x = {req.second_end_x[COORD_WIDTH-1],   req.second_end_x};
   assign b2y = {req.second_end_y[COORD_WIDTH-1],   req.second_end_y};

   // Stage one: differences against each origin, and box membership of each endpoint.
   logic signed [DW-1:0] ux_in [NUM_ORIENT];
   logic signed [DW-1:0] uy_in [NUM_ORIENT];
   logic signed [DW-1:0] vx_in [NUM_SEG];
   logic signed [DW-1:0] vy_in [NUM_SEG];
   logic [NUM_ORIENT-1:0] box_in;

   always_comb begin
      // Orientations 0 and 1 use segment b as reference, 2 and 3 use segment a.
      vx_in[0] = b2x - b1x;
      vy_in[0] = b2y - b1y;
      vx_in[1] = a2x - a1x;
      vy_in[1] = a2y - a1y;
      ux_in[0] = a1x - b1x;
      uy_in[0] = a1y - b1y;
      ux_in[1] = a2x - b1x;
      uy_in[1] = a2y - b1y;
      ux_in[2] = b1x - a1x;
      uy_in[2] = b1y - a1y;
      ux_in[3] = b2x - a1x;
      uy_in[3] = b2y - a1y;

      box_in[0] = ((b1x <= a1x && a1x <= b2x) || (b2x <= a1x && a1x <= b1x)) &&
                  ((b1y <= a1y && a1y <= b2y) || (b2y <= a1y && a1y <= b1y));
      box_in[1] = ((b1x <= a2x && a2x <= b2x) || (b2x <= a2x && a2x <= b1x)) &&
                  ((b1y <= a2y && a2y <= b2y) || (b2y <= a2y && a2y <= b1y));
      box_in[2] = ((a1x <= b1x && b1x <= a2x) || (a2x <= b1x && b1x <= a1x)) &&
                  ((a1y <= b1y && b1y <= a2y) || (a2y <= b1y && b1y <= a1y));
      box_in[3] = ((a1x <= b2x && b2x <= a2x) || (a2x <= b2x && b2x <= a1x)) &&
                  ((a1y <= b2y && b2y <= a2y) || (a2y <= b2y && b2y <= a1y));
   end

   logic signed [DW-1:0] ux_ff [NUM_ORIENT];
   logic signed [DW-1:0] uy_ff [NUM_ORIENT];
   logic signed [DW-1:0] vx_ff [NUM_SEG];
   logic signed [DW-1:0] vy_ff [NUM_SEG];
   logic [NUM_ORIENT-1:0] box1_ff, box2_ff, box3_ff;

   // Stage two: both products of every cross product, kept at full width.
   logic signed [PW-1:0] lhs_ff [NUM_ORIENT];
   logic signed [PW-1:0] rhs_ff [NUM_ORIENT];

   // Stage three: sign of each cross product from comparing its two products.
   sign_type sgn_ff [NUM_ORIENT];

   // Advance the payload; no reset needed.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_ORIENT; k++) begin
            ux_ff[k]  <= ux_in[k];
            uy_ff[k]  <= uy_in[k];
            lhs_ff[k] <= PW'(ux_ff[k]) * PW'(vy_ff[k / 2]);
            rhs_ff[k] <= PW'(vx_ff[k / 2]) * PW'(uy_ff[k]);
            sgn_ff[k].pos <= lhs_ff[k] > rhs_ff[k];
            sgn_ff[k].neg <= lhs_ff[k] < rhs_ff[k];
         end
         for (int s = 0; s < NUM_SEG; s++) begin
            vx_ff[s] <= vx_in[s];
            vy_ff[s] <= vy_in[s];
         end
         box1_ff <= box_in;
         box2_ff <= box1_ff;
         box3_ff <= box2_ff;
      end
   end

   // Final decision: proper crossing, else a collinear endpoint inside the other box.
   logic cross_b, cross_a, touch, meet_in;
   always_comb begin
      cross_b = (sgn_ff[0].pos && sgn_ff[1].neg) || (sgn_ff[0].neg && sgn_ff[1].pos);
      cross_a = (sgn_ff[2].pos && sgn_ff[3].neg) || (sgn_ff[2].neg && sgn_ff[3].pos);
      touch   = 1'b0;
      for (int k = 0; k < NUM_ORIENT; k++) begin
         touch = touch || (!sgn_ff[k].pos && !sgn_ff[k].neg && box3_ff[k]);
      end
      meet_in = (cross_a && cross_b) || touch;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meet_ff <= meet_in;
      end
   end

   // Advance the valid bits alongside the data; clear them on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.segments_meet = meet_ff;

   // Checks on the pipeline control.
   `SIT_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, v1_ff,
                    "accepted request did not enter stage one")
   `SIT_ASSERT_NEXT(a_stall_holds, !advance,
                    $stable({v1_ff, v2_ff, v3_ff}) && rsp_valid_ff && $stable(meet_ff),
                    "pipeline moved during a stall")
   `SIT_ASSERT_NEXT(a_crossing_meets, v3_ff && advance && cross_a && cross_b,
                    rsp_valid_ff && meet_ff,
                    "proper crossing not reported as meeting")

endmodule
